@@ rtl/core/hdu_pkg.sv @@
// ----------------------------------------------------------------------------
// Haversine distance package
// Constants, pipeline stage types and helper functions shared by the
// great-circle distance pipeline and its checker.
// ----------------------------------------------------------------------------
package hdu_pkg;

    // Pipeline depth: input, reduction (2), scaling (2), rotation CORDIC,
    // clamp, products (4), square roots, vectoring CORDIC, scaling (2).
    localparam int HDU_CORDIC_STEPS = 31;
    localparam int HDU_SQRT_STEPS   = 31;
    localparam int HDU_LATENCY      = 105;

    // Angles in degrees times 2^23.
    localparam logic signed [33:0] Q23_HALF    = 34'sd1509949440;
    localparam logic signed [33:0] Q23_FULL    = 34'sd3019898880;
    localparam logic signed [33:0] Q23_QUARTER = 34'sd754974720;

    // Degrees to radians, Q40, split into two partial products.
    localparam logic [34:0] DEG_TO_RAD_Q40 = 35'd19190098069;
    localparam logic [16:0] D2R_HI         = DEG_TO_RAD_Q40[34:18];
    localparam logic [17:0] D2R_LO         = DEG_TO_RAD_Q40[17:0];

    localparam logic signed [32:0] GAIN_INV_Q30 = 33'sd652032874;
    localparam logic signed [32:0] ONE_Q30_S    = 33'sd1073741824;
    localparam logic [30:0]        ONE_Q30      = 31'd1073741824;
    localparam logic [60:0]        ONE_Q60      = 61'd1152921504606846976;

    // Twice the radius in sixteenths of a meter, and the saturation limit.
    localparam logic [27:0] DIST_SCALE = 28'd203872000;
    localparam logic [28:0] HALF_CIRC  = 29'd320241389;

    // Arctangent of 2^-i in radians Q30 for the first ten steps.
    localparam logic signed [32:0] ATAN_TAB [0:9] = '{
        33'sd843314857, 33'sd497837829, 33'sd263043837, 33'sd133525159,
        33'sd67021687,  33'sd33543516,  33'sd16775851,  33'sd8388437,
        33'sd4194283,   33'sd2097149
    };

    // Rotation stage state.
    typedef struct packed {
        logic signed [32:0] x;
        logic signed [32:0] y;
        logic signed [32:0] z;
        logic               cneg;
    } t_cord;

    // Square root stage state.
    typedef struct packed {
        logic [60:0] rem;
        logic [61:0] root;
    } t_sqrt;

    // Vectoring stage state.
    typedef struct packed {
        logic signed [61:0] x;
        logic signed [61:0] y;
        logic signed [32:0] z;
    } t_vec;

    // Angle step of CORDIC stage i; beyond the table it is a plain power of two.
    function automatic logic signed [32:0] atan_q30(input int i);
        if (i < 10) begin
            return ATAN_TAB[i[3:0]];
        end
        return 33'sd1 <<< (30 - i);
    endfunction

endpackage

@@ rtl/core/haversine_distance_unit.sv @@
// ----------------------------------------------------------------------------
// Haversine distance unit
// Fully pipelined great-circle distance between two coordinate points.
// ----------------------------------------------------------------------------
// Usage:
// A coordinate pair is transferred on a rising edge with start high and busy
// low. busy stays low, so a new pair can be transferred on every cycle and
// the sustained rate is one pair per clock.
// Each pair gives one distance, in sixteenths of a meter, on o_distance_sixteenths.
// It is shown for exactly one cycle with o_valid high, in the order the pairs came in.
// The latency is set by the 31-step rotation CORDIC, the 31-step square
// root and the 31-step vectoring CORDIC, one step per pipeline stage, plus
// twelve stages of input, angle reduction, scaling, clamping and products.
// A synchronous reset (i_rst_n low) clears all valid bits, so any pairs in
// flight are dropped; the data path itself is not reset.
// The receiver cannot stall the block: every result must be taken in the
// cycle it is shown.
// ----------------------------------------------------------------------------
module haversine_distance_unit import hdu_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [29:0] i_first_latitude,
    input  logic signed [30:0] i_first_longitude,
    input  logic signed [29:0] i_second_latitude,
    input  logic signed [30:0] i_second_longitude,
    output logic               o_valid,
    output logic [28:0]        o_distance_sixteenths
);

    // One rotation step toward angle zero.
    function automatic t_cord rot_step(input t_cord s, input int i);
        logic signed [32:0] xs;
        logic signed [32:0] ys;
        t_cord              o;
        xs = s.x >>> i;
        ys = s.y >>> i;
        o  = s;
        if (s.z >= 0) begin
            o.x = s.x - ys;
            o.y = s.y + xs;
            o.z = s.z - atan_q30(i);
        end else begin
            o.x = s.x + ys;
            o.y = s.y - xs;
            o.z = s.z + atan_q30(i);
        end
        return o;
    endfunction

    // One digit of the integer square root, trial bit 2^(60-2k).
    function automatic t_sqrt sqrt_step(input t_sqrt s, input int k);
        logic [61:0] bitv;
        logic [61:0] trial;
        t_sqrt       o;
        bitv  = 62'd1 << (60 - 2 * k);
        trial = s.root + bitv;
        if ({1'b0, s.rem} >= trial) begin
            o.rem  = s.rem - trial[60:0];
            o.root = (s.root >> 1) + bitv;
        end else begin
            o.rem  = s.rem;
            o.root = s.root >> 1;
        end
        return o;
    endfunction

    // One vectoring step that drives y toward zero.
    function automatic t_vec vec_step(input t_vec s, input int i);
        logic signed [61:0] xs;
        logic signed [61:0] ys;
        t_vec               o;
        xs = s.x >>> i;
        ys = s.y >>> i;
        if (s.y > 0) begin
            o.x = s.x + ys;
            o.y = s.y - xs;
            o.z = s.z + atan_q30(i);
        end else begin
            o.x = s.x - ys;
            o.y = s.y + xs;
            o.z = s.z - atan_q30(i);
        end
        return o;
    endfunction

    // Clamp a rotation result to the unit range.
    function automatic logic [30:0] clamp_unit(input logic signed [32:0] v);
        if (v < 0) begin
            return 31'd0;
        end
        if (v > ONE_Q30_S) begin
            return ONE_Q30;
        end
        return v[30:0];
    endfunction

    logic [HDU_LATENCY-1:0] r_vld;

    logic signed [33:0] r_ang   [0:3];
    logic signed [33:0] r_fold  [0:3];
    logic [29:0]        r_mag   [0:3];
    logic               r_cneg3 [0:3];
    logic [46:0]        r_p_hi  [0:3];
    logic [47:0]        r_p_lo  [0:3];
    logic               r_cneg4 [0:3];
    t_cord              r_rot   [0:HDU_CORDIC_STEPS][0:3];

    logic [30:0]        r_sa;
    logic [30:0]        r_sb;
    logic signed [31:0] r_c1;
    logic signed [31:0] r_c2;
    logic [60:0]        r_sa2_1;
    logic [30:0]        r_sb_1;
    logic [30:0]        r_tmag;
    logic               r_tneg;
    logic [60:0]        r_sa2_2;
    logic [30:0]        r_sb_2;
    logic [30:0]        r_umag;
    logic               r_uneg_2;
    logic [60:0]        r_sa2_3;
    logic [61:0]        r_usb;
    logic               r_uneg_3;
    logic [60:0]        r_a;

    t_sqrt              w_sq_init [0:1];
    t_sqrt              r_sq      [0:HDU_SQRT_STEPS-1][0:1];
    t_vec               w_vec_init;
    t_vec               r_vec     [0:HDU_CORDIC_STEPS-1];

    logic [58:0]        r_prod;
    logic [28:0]        r_dist;

    logic [59:0]        n_dsum;
    logic [29:0]        n_dist;

    // The pipeline never holds off a transfer.
    assign busy = 1'b0;

    // Valid bits move along with the data, one stage per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[HDU_LATENCY-2:0], start && !busy};
        end
    end

    // Stage 1: angle differences and doubled latitudes in degrees times 2^23.
    always_ff @(posedge i_clk) begin
        r_ang[0] <= 34'(i_second_latitude) - 34'(i_first_latitude);
        r_ang[1] <= 34'(i_second_longitude) - 34'(i_first_longitude);
        r_ang[2] <= 34'(i_first_latitude) <<< 1;
        r_ang[3] <= 34'(i_second_latitude) <<< 1;
    end

    // Stages 2 to 5: reduce each angle to the first quadrant and scale to radians.
    for (genvar l = 0; l < 4; l++) begin : g_reduce
        logic signed [33:0] n_abs;
        logic [65:0]        n_zsum;

        always_comb begin
            n_abs  = (r_fold[l] < 0) ? -r_fold[l] : r_fold[l];
            n_zsum = 66'({r_p_hi[l], 18'd0}) + 66'(r_p_lo[l]) + (66'd1 << 32);
        end

        always_ff @(posedge i_clk) begin
            // Fold into the half-open range around zero.
            if (r_ang[l] > Q23_HALF) begin
                r_fold[l] <= r_ang[l] - Q23_FULL;
            end else if (r_ang[l] <= -Q23_HALF) begin
                r_fold[l] <= r_ang[l] + Q23_FULL;
            end else begin
                r_fold[l] <= r_ang[l];
            end

            // Mirror the second quadrant; the cosine changes sign there.
            if (n_abs > Q23_QUARTER) begin
                r_mag[l]   <= 30'(Q23_HALF - n_abs);
                r_cneg3[l] <= 1'b1;
            end else begin
                r_mag[l]   <= n_abs[29:0];
                r_cneg3[l] <= 1'b0;
            end

            r_p_hi[l]  <= 47'(r_mag[l]) * 47'(D2R_HI);
            r_p_lo[l]  <= 48'(r_mag[l]) * 48'(D2R_LO);
            r_cneg4[l] <= r_cneg3[l];

            r_rot[0][l].x    <= GAIN_INV_Q30;
            r_rot[0][l].y    <= '0;
            r_rot[0][l].z    <= signed'(n_zsum[65:33]);
            r_rot[0][l].cneg <= r_cneg4[l];
        end
    end

    // Rotation CORDIC, one step per stage, four lanes side by side.
    for (genvar i = 0; i < HDU_CORDIC_STEPS; i++) begin : g_rot
        for (genvar l = 0; l < 4; l++) begin : g_lane
            always_ff @(posedge i_clk) begin
                r_rot[i+1][l] <= rot_step(r_rot[i][l], i);
            end
        end
    end

    // Clamp and sign: half-difference sines as magnitudes, latitude cosines signed.
    always_ff @(posedge i_clk) begin
        r_sa <= clamp_unit(r_rot[HDU_CORDIC_STEPS][0].y);
        r_sb <= clamp_unit(r_rot[HDU_CORDIC_STEPS][1].y);
        r_c1 <= r_rot[HDU_CORDIC_STEPS][2].cneg
              ? -32'(clamp_unit(r_rot[HDU_CORDIC_STEPS][2].x))
              :  32'(clamp_unit(r_rot[HDU_CORDIC_STEPS][2].x));
        r_c2 <= r_rot[HDU_CORDIC_STEPS][3].cneg
              ? -32'(clamp_unit(r_rot[HDU_CORDIC_STEPS][3].x))
              :  32'(clamp_unit(r_rot[HDU_CORDIC_STEPS][3].x));
    end

    // Product stages, kept in sign and magnitude so truncation is toward zero.
    always_ff @(posedge i_clk) begin
        logic [30:0] ma;
        logic [30:0] mb;
        logic [61:0] pt;
        logic [61:0] pu;
        logic signed [62:0] sum;
        ma = (r_c1 < 0) ? 31'(-r_c1) : r_c1[30:0];
        mb = (r_c2 < 0) ? 31'(-r_c2) : r_c2[30:0];
        pt = 62'(ma) * 62'(mb);
        pu = 62'(r_tmag) * 62'(r_sb_1);

        r_tmag  <= pt[60:30];
        r_tneg  <= (r_c1 < 0) != (r_c2 < 0);
        r_sa2_1 <= 61'(62'(r_sa) * 62'(r_sa));
        r_sb_1  <= r_sb;

        r_umag   <= pu[60:30];
        r_uneg_2 <= r_tneg;
        r_sa2_2  <= r_sa2_1;
        r_sb_2   <= r_sb_1;

        r_usb    <= 62'(r_umag) * 62'(r_sb_2);
        r_uneg_3 <= r_uneg_2;
        r_sa2_3  <= r_sa2_2;

        // The sum a, held to the unit range in Q60.
        sum = r_uneg_3 ? 63'(r_sa2_3) - 63'(r_usb) : 63'(r_sa2_3) + 63'(r_usb);
        if (sum < 0) begin
            r_a <= '0;
        end else if (sum > 63'(ONE_Q60)) begin
            r_a <= ONE_Q60;
        end else begin
            r_a <= sum[60:0];
        end
    end

    // Square roots of a and of one minus a, one result bit per stage.
    always_comb begin
        w_sq_init[0].rem  = r_a;
        w_sq_init[0].root = '0;
        w_sq_init[1].rem  = ONE_Q60 - r_a;
        w_sq_init[1].root = '0;
    end

    for (genvar k = 0; k < HDU_SQRT_STEPS; k++) begin : g_sqrt
        for (genvar l = 0; l < 2; l++) begin : g_lane
            if (k == 0) begin : g_first
                always_ff @(posedge i_clk) begin
                    r_sq[k][l] <= sqrt_step(w_sq_init[l], k);
                end
            end else begin : g_next
                always_ff @(posedge i_clk) begin
                    r_sq[k][l] <= sqrt_step(r_sq[k-1][l], k);
                end
            end
        end
    end

    // Vectoring CORDIC for the half central angle.
    always_comb begin
        w_vec_init.x = 62'(r_sq[HDU_SQRT_STEPS-1][1].root[30:0]) <<< 28;
        w_vec_init.y = 62'(r_sq[HDU_SQRT_STEPS-1][0].root[30:0]) <<< 28;
        w_vec_init.z = '0;
    end

    for (genvar i = 0; i < HDU_CORDIC_STEPS; i++) begin : g_vec
        if (i == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                r_vec[i] <= vec_step(w_vec_init, i);
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                r_vec[i] <= vec_step(r_vec[i-1], i);
            end
        end
    end

    // Scale the angle to a distance, round, and saturate at half the circumference.
    always_comb begin
        n_dsum = 60'(r_prod) + (60'd1 << 29);
        n_dist = n_dsum[59:30];
    end

    always_ff @(posedge i_clk) begin
        if (r_vec[HDU_CORDIC_STEPS-1].z < 0) begin
            r_prod <= '0;
        end else begin
            r_prod <= 59'(r_vec[HDU_CORDIC_STEPS-1].z[30:0]) * 59'(DIST_SCALE);
        end
        if (n_dist > 30'(HALF_CIRC)) begin
            r_dist <= HALF_CIRC;
        end else begin
            r_dist <= n_dist[28:0];
        end
    end

    assign o_valid               = r_vld[HDU_LATENCY-1];
    assign o_distance_sixteenths = r_dist;

endmodule

@@ rtl/core/hdu_checker.sv @@
// ----------------------------------------------------------------------------
// Haversine distance checker
// Port-level timing and range checks, bound to the distance unit.
// ----------------------------------------------------------------------------
module hdu_checker import hdu_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic [28:0] o_distance_sixteenths
);

    // Every transfer yields exactly one result after the fixed latency.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##HDU_LATENCY o_valid)
        else $error("result missing after a start transfer");

    // No result without a transfer one latency earlier.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, HDU_LATENCY))
        else $error("result without a matching start transfer");

    // A distance never exceeds half the circumference.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_distance_sixteenths <= HALF_CIRC)
        else $error("distance beyond half the circumference");

    // Reset flushes the pipeline.
    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result shown right after reset");

endmodule

bind haversine_distance_unit hdu_checker u_hdu_checker (.*);
